>>> rtl/itm_pkg.sv
// Package for the interval timer: item, result and state types, register
// codes and constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itm_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_TICK      = 2'd2,
    OP_BUS_RESET = 2'd3
  } itm_op_t;

  // Register selects
  localparam logic REG_CSR   = 1'b0;
  localparam logic REG_VALUE = 1'b1;

  // CSR bit positions
  localparam int CSR_EN_BIT   = 0;
  localparam int CSR_PEND_BIT = 1;

  localparam int          DATA_W         = 8;
  localparam int          COUNT_W        = 16;
  localparam int          PRESC_W        = 4;
  localparam logic [7:0]  VALUE_READBACK = 8'hFF;

  typedef struct packed {
    itm_op_t     op;
    logic        reg_index;
    logic [7:0]  write_data;
  } itm_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
  } itm_out_t;

  typedef struct packed {
    logic                enable;
    logic                pending;
    logic [COUNT_W-1:0]  reload;
    logic [COUNT_W-1:0]  countdown;
    logic [PRESC_W-1:0]  prescale;
  } itm_state_t;

  localparam itm_state_t STATE_RESET = '0;

endpackage : itm_pkg

`default_nettype wire

>>> rtl/itm_step.sv
// Next-state and result logic for one timer item.
// Depends on itm_pkg for the item, result and state types.
`timescale 1ns / 1ps
`default_nettype none

module itm_step #(
  parameter int PRESCALE_DIV = 16
) (
  input  itm_pkg::itm_state_t cur_state,
  input  itm_pkg::itm_in_t    item,
  output itm_pkg::itm_state_t nxt_state,
  output itm_pkg::itm_out_t   result
);
  import itm_pkg::*;

  localparam logic [PRESC_W:0] DIV_L = (PRESC_W+1)'(PRESCALE_DIV);

  logic [PRESC_W:0] presc_sum;
  logic [7:0]       rd;

  assign presc_sum = {1'b0, cur_state.prescale} + {{PRESC_W{1'b0}}, 1'b1};

  // Decode the item and update the state
  always_comb begin
    nxt_state = cur_state;
    rd        = '0;
    unique case (item.op)
      OP_READ: begin
        if (item.reg_index == REG_CSR) begin
          rd[CSR_EN_BIT]    = cur_state.enable;
          rd[CSR_PEND_BIT]  = cur_state.pending;
          nxt_state.pending = 1'b0;
        end else begin
          rd = VALUE_READBACK;
        end
      end
      OP_WRITE: begin
        if (item.reg_index == REG_CSR) begin
          if (item.write_data[CSR_EN_BIT] != cur_state.enable) begin
            nxt_state.enable  = item.write_data[CSR_EN_BIT];
            nxt_state.pending = 1'b0;
            if (item.write_data[CSR_EN_BIT]) begin
              nxt_state.countdown = cur_state.reload;
              nxt_state.prescale  = '0;
            end
          end
        end else begin
          nxt_state.reload  = {cur_state.reload[COUNT_W-DATA_W-1:0], item.write_data};
          nxt_state.enable  = 1'b0;
          nxt_state.pending = 1'b0;
        end
      end
      OP_TICK: begin
        if (cur_state.enable) begin
          if (presc_sum >= DIV_L) begin
            // One timer tick: expire on zero or one, else count down
            nxt_state.prescale = '0;
            if (cur_state.countdown <= COUNT_W'(1)) begin
              nxt_state.pending   = 1'b1;
              nxt_state.countdown = cur_state.reload;
            end else begin
              nxt_state.countdown = cur_state.countdown - COUNT_W'(1);
            end
          end else begin
            nxt_state.prescale = presc_sum[PRESC_W-1:0];
          end
        end
      end
      OP_BUS_RESET: begin
        nxt_state = STATE_RESET;
      end
      default: begin
        nxt_state = cur_state;
      end
    endcase
  end

  assign result.read_data = rd;
  assign result.irq       = nxt_state.enable & nxt_state.pending;

endmodule : itm_step

`default_nettype wire

>>> rtl/interval_timer_with_csr.sv
// Interval timer with CSR and reload value register: state registers and
// output register around itm_step. Depends on itm_pkg and itm_step.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one item per
//   accepted cycle: a register read, a register write, an input clock tick
//   or a bus reset. Every item yields exactly one result on the output
//   channel (out_valid, out_stall, out_data): read data and the interrupt
//   line as it stands after that item.
//   The state updates and the result is registered at the edge that accepts
//   the item. Throughput is one item per cycle while the receiver does not
//   stall, set by the single-pass update between state and output registers.
//   When the receiver stalls, the result holds in the output register and
//   in_stall rises only while that register is full and stalled, so a new
//   item is taken in the same cycle the previous result drains.
//   Reset (rst_n low, synchronous) clears enable, pending, reload value,
//   countdown and prescaler and empties the output register. A bus reset
//   item has the same effect on the timer state and still yields a result.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_with_csr #(
  parameter int PRESCALE_DIV = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  itm_pkg::itm_in_t    in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output itm_pkg::itm_out_t   out_data
);
  import itm_pkg::*;

  itm_state_t state_r;
  itm_state_t state_nxt;
  itm_out_t   result;
  itm_out_t   out_data_r;
  logic       out_valid_r;
  logic       accept;

  // Stall the input only while a result waits and the receiver stalls
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  itm_step #(
    .PRESCALE_DIV(PRESCALE_DIV)
  ) u_step (
    .cur_state(state_r),
    .item     (in_data),
    .nxt_state(state_nxt),
    .result   (result)
  );

  // Advance the timer state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : interval_timer_with_csr

`default_nettype wire

>>> bench/tb_interval_timer_with_csr.sv
// Self-checking bench for interval_timer_with_csr: a directed opening, then random
// timer programming runs under four idle/stall mixes, checked item by item.
// Depends on itm_pkg and the timer RTL.
`timescale 1ns / 1ps

module tb_interval_timer_with_csr;
  import itm_pkg::*;

  localparam int PRESC_DIV     = 16;
  localparam int ITEMS_PER_MIX = 300;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  itm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  itm_out_t out_data;

  // Idle and stall percentages, one entry per traffic mix
  int in_idle_by_mix[4]   = '{0, 69, 0, 21};
  int out_stall_by_mix[4] = '{0, 0, 69, 21};
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  itm_in_t    item_queue[$];
  itm_out_t   expected_results[$];
  itm_state_t timer_st = STATE_RESET;
  int         check_errors = 0;
  int         items_queued;

  interval_timer_with_csr #(
    .PRESCALE_DIV(PRESC_DIV)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // Advance the timer state by one item and return the result it gives
  function automatic itm_out_t timer_predict(input itm_in_t it);
    itm_out_t r;
    r = '0;
    case (it.op)
      OP_READ: begin
        if (it.reg_index == REG_CSR) begin
          r.read_data[CSR_EN_BIT]   = timer_st.enable;
          r.read_data[CSR_PEND_BIT] = timer_st.pending;
          timer_st.pending = 1'b0;
        end else begin
          r.read_data = VALUE_READBACK;
        end
      end
      OP_WRITE: begin
        if (it.reg_index == REG_CSR) begin
          if (it.write_data[CSR_EN_BIT] != timer_st.enable) begin
            timer_st.enable  = it.write_data[CSR_EN_BIT];
            timer_st.pending = 1'b0;
            if (timer_st.enable) begin
              timer_st.countdown = timer_st.reload;
              timer_st.prescale  = '0;
            end
          end
        end else begin
          timer_st.reload  = {timer_st.reload[7:0], it.write_data};
          timer_st.enable  = 1'b0;
          timer_st.pending = 1'b0;
        end
      end
      OP_TICK: begin
        if (timer_st.enable) begin
          if (int'(timer_st.prescale) + 1 >= PRESC_DIV) begin
            timer_st.prescale = '0;
            // Expire on zero or one, else count down
            if (timer_st.countdown <= 1) begin
              timer_st.pending   = 1'b1;
              timer_st.countdown = timer_st.reload;
            end else begin
              timer_st.countdown = timer_st.countdown - 1'b1;
            end
          end else begin
            timer_st.prescale = timer_st.prescale + 1'b1;
          end
        end
      end
      default: begin
        timer_st = STATE_RESET;
      end
    endcase
    r.irq = timer_st.enable & timer_st.pending;
    return r;
  endfunction

  // Queue one item and count it toward the current mix
  task automatic queue_item(input itm_op_t op, input logic ri, input logic [7:0] d);
    itm_in_t it;
    it.op         = op;
    it.reg_index  = ri;
    it.write_data = d;
    item_queue.push_back(it);
    items_queued++;
  endtask

  // Program a short reload, enable, then tick with register traffic mixed in
  task automatic queue_timer_run();
    logic [7:0] hi;
    logic [7:0] lo;
    int         n_ticks;
    int         pick;
    hi = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
    lo = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    queue_item(OP_WRITE, REG_VALUE, hi);
    queue_item(OP_WRITE, REG_VALUE, lo);
    queue_item(OP_WRITE, REG_CSR, {7'($urandom), 1'b1});
    n_ticks = $urandom_range(16, 100);
    for (int i = 0; i < n_ticks; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) queue_item(OP_READ, REG_CSR, 8'($urandom));
      else if (pick < 10) queue_item(OP_READ, REG_VALUE, 8'($urandom));
      else if (pick < 12) queue_item(OP_WRITE, REG_CSR, 8'($urandom));
      queue_item(OP_TICK, 1'($urandom), 8'($urandom));
    end
    pick = $urandom_range(9);
    if (pick < 3) queue_item(OP_WRITE, REG_CSR, {7'($urandom), 1'b0});
    else if (pick < 5) queue_item(OP_BUS_RESET, 1'($urandom), 8'($urandom));
    else if (pick < 8) queue_item(OP_READ, REG_CSR, 8'($urandom));
  endtask

  // Stimulus: directed opening, then random runs per traffic mix
  initial begin
    items_queued = 0;
    // Hold reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reads after reset, shift the reload through 0xFF00 to zero
    queue_item(OP_READ, REG_CSR, 8'h00);
    queue_item(OP_WRITE, REG_VALUE, 8'hFF);
    queue_item(OP_WRITE, REG_VALUE, 8'h00);
    queue_item(OP_WRITE, REG_VALUE, 8'h00);
    // CSR write with enable unchanged, then enable with a zero reload
    queue_item(OP_WRITE, REG_CSR, 8'hFE);
    queue_item(OP_WRITE, REG_CSR, 8'h01);
    for (int i = 0; i < PRESC_DIV; i++) queue_item(OP_TICK, 1'b0, 8'h00);
    queue_item(OP_READ, REG_VALUE, 8'hFF);
    queue_item(OP_READ, REG_CSR, 8'h00);
    // Reload of one, enable with all data bits set, then bus reset
    queue_item(OP_WRITE, REG_VALUE, 8'h01);
    queue_item(OP_WRITE, REG_CSR, 8'hFF);
    queue_item(OP_BUS_RESET, 1'b1, 8'hFF);
    queue_item(OP_READ, REG_CSR, 8'h00);

    for (int mix = 0; mix < 4; mix++) begin
      in_idle_pct   = in_idle_by_mix[mix];
      out_stall_pct = out_stall_by_mix[mix];
      items_queued  = 0;
      while (items_queued < ITEMS_PER_MIX) begin
        if ($urandom_range(9) < 8) begin
          queue_timer_run();
        end else begin
          queue_item(itm_op_t'($urandom_range(3)), 1'($urandom), 8'($urandom));
        end
      end
      while (item_queue.size() != 0) @(posedge clk);
    end

    // Drain outstanding results
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (check_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Driver: predict on acceptance, then present the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(timer_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (item_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_data  <= item_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    itm_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: read_data %0h irq %0b",
                 out_data.read_data, out_data.irq);
          check_errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            check_errors++;
          end
          if (out_data.irq !== want.irq) begin
            $error("irq: expected %0b, got %0b", want.irq, out_data.irq);
            check_errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
